// File: rtl/turing_machine_step_engine_defines.svh
// Assertion macros shared by the turing machine step engine RTL.
// Both forms sample on aclk and are disabled while aresetn is low.
`ifndef TURING_MACHINE_STEP_ENGINE_DEFINES_SVH
`define TURING_MACHINE_STEP_ENGINE_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define TME_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("turing machine step engine: same-cycle check failed");

// Next-cycle implication.
`define TME_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("turing machine step engine: next-cycle check failed");

`else

`define TME_ASSERT_IMPL(label, ante, cons)
`define TME_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// File: rtl/tme_pkg.sv
package tme_pkg;

    localparam int TME_RULE_DEPTH = 64;
    localparam int TME_TAPE_DEPTH = 1024;

    localparam logic [7:0] TME_BLANK = 8'd32;

    // Item actions
    localparam logic [2:0] ACT_LOAD_RULE  = 3'd0;
    localparam logic [2:0] ACT_WRITE_TAPE = 3'd1;
    localparam logic [2:0] ACT_READ_TAPE  = 3'd2;
    localparam logic [2:0] ACT_RESTART    = 3'd3;
    localparam logic [2:0] ACT_STEP       = 3'd4;

    // Rule operations
    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_RIGHT = 2'd1;
    localparam logic [1:0] OP_LEFT  = 2'd2;
    localparam logic [1:0] OP_HALT  = 2'd3;

    // Run status
    localparam logic [1:0] RUN_RUNNING  = 2'd0;
    localparam logic [1:0] RUN_HALTED   = 2'd1;
    localparam logic [1:0] RUN_NOMATCH  = 2'd2;
    localparam logic [1:0] RUN_OVERFLOW = 2'd3;

    // Configuration register indexes
    localparam int TME_CFG_IW = 2;
    localparam logic [TME_CFG_IW-1:0] CFG_START_STATE = 2'd0;
    localparam logic [TME_CFG_IW-1:0] CFG_START_HEAD  = 2'd1;
    localparam logic [TME_CFG_IW-1:0] CFG_RULE_COUNT  = 2'd2;

    typedef struct packed {
        logic [7:0] st;
        logic [7:0] sym;
        logic [1:0] op;
        logic [7:0] wr;
        logic [7:0] nx;
    } tme_rule_t;

    typedef struct packed {
        logic       start;
        logic [7:0] state;
        logic [7:0] sym;
        logic [6:0] count;
    } tme_scan_req_t;

    typedef struct packed {
        logic      done;
        logic      hit;
        tme_rule_t rule;
    } tme_scan_res_t;

endpackage

// File: rtl/turing_machine_step_engine.sv
// Single-tape Turing machine engine. Each accepted input beat carries one action (load rule,
// write tape, read tape, restart, step) and produces exactly one result beat reporting the
// machine state, head, symbol, run status and tape extent. The block handles one item at a
// time: s_ready is high only while the sequencer is idle, but a finished result may wait in
// the output register while the next item is taken. Each item passes through the states
// ST_EXEC, ST_FINAL and ST_RESP; a running step first fetches the symbol under the head,
// then scans the rules with one compare per rule, stopping at the first match, over
// N = min(rule_count, RULE_DEPTH) rules, since the rule memory delivers one rule per cycle
// to a single shared state/symbol comparator. Any tape write (write tape, a write rule, a
// move right to a cell at or past the extent) passes through ST_WR; one that lands past
// the current extent first fills the skipped cells with blank through the single tape
// write port, one cell per cycle. s_ready returns in the same cycle as m_valid for the
// result. Cells at or past the extent read as blank (32). Configuration is to be written on
// cfg_wr_en only while the block is idle; the block itself does not enforce this.
`include "turing_machine_step_engine_defines.svh"

module turing_machine_step_engine import tme_pkg::*; #(
    parameter int RULE_DEPTH = TME_RULE_DEPTH,
    parameter int TAPE_DEPTH = TME_TAPE_DEPTH
) (
    input  logic                  aclk,
    input  logic                  aresetn,

    // configuration write port
    input  logic                  cfg_wr_en,
    input  logic [TME_CFG_IW-1:0] cfg_index,
    input  logic [9:0]            cfg_wdata,

    // input channel
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [2:0]            s_action,
    input  logic [5:0]            s_rule_index,
    input  logic [7:0]            s_rule_state,
    input  logic [7:0]            s_rule_symbol,
    input  logic [1:0]            s_rule_op,
    input  logic [7:0]            s_rule_write,
    input  logic [7:0]            s_rule_next,
    input  logic [9:0]            s_tape_addr,
    input  logic [7:0]            s_tape_symbol,

    // result channel
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [7:0]            m_machine_state,
    output logic [9:0]            m_head_pos,
    output logic [7:0]            m_symbol_out,
    output logic [1:0]            m_run_state,
    output logic [10:0]           m_extent
);

    localparam int AW  = $clog2(TAPE_DEPTH);
    localparam int EW  = $clog2(TAPE_DEPTH + 1);
    localparam int CW  = (EW > 11) ? EW : 11;
    localparam int RIW = (RULE_DEPTH > 1) ? $clog2(RULE_DEPTH) : 1;

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_EXEC  = 7'b0000010,
        ST_SYM   = 7'b0000100,
        ST_SCAN  = 7'b0001000,
        ST_WR    = 7'b0010000,
        ST_FINAL = 7'b0100000,
        ST_RESP  = 7'b1000000
    } tme_fsm_t;

    tme_fsm_t state_reg, state_next;

    // latched input item
    logic [2:0] act_reg;
    logic [5:0] rule_index_reg;
    tme_rule_t  in_rule_reg;
    logic [9:0] addr_reg;
    logic [7:0] tsym_reg;

    // machine state
    logic [7:0]    mstate_reg, mstate_next;
    logic [AW-1:0] head_reg, head_next;
    logic [1:0]    status_reg, status_next;
    logic [EW-1:0] extent_reg, extent_next;

    // configuration
    logic [7:0] start_state_reg;
    logic [9:0] start_head_reg;
    logic [6:0] rule_count_reg;

    // pending tape write target
    logic [AW-1:0] wa_reg, wa_next;
    logic [7:0]    wd_reg, wd_next;

    // tape memory
    logic [7:0]    tape_mem [TAPE_DEPTH];
    logic [7:0]    tape_rdata_reg;
    logic          tape_we;
    logic [AW-1:0] tape_waddr;
    logic [7:0]    tape_wdata;
    logic [AW-1:0] tape_raddr;

    // result register
    logic        m_valid_reg, m_valid_next;
    logic [7:0]  m_machine_state_reg;
    logic [9:0]  m_head_pos_reg;
    logic [7:0]  m_symbol_out_reg;
    logic [1:0]  m_run_state_reg;
    logic [10:0] m_extent_reg;
    logic        out_load;

    // rule scanner
    logic          rule_wr_en;
    tme_scan_req_t scan_req;
    tme_scan_res_t scan_res;

    // common-width views for compares
    logic [CW-1:0] head_cw;
    logic [CW-1:0] head_inc_cw;
    logic [CW-1:0] extent_cw;
    logic [CW-1:0] addr_cw;
    logic [CW-1:0] wa_cw;
    logic [CW-1:0] start_head_cw;
    logic [CW-1:0] out_addr_cw;
    logic          idx_ok;
    logic          addr_ok;
    logic          is_read;
    logic [7:0]    head_sym;
    logic [7:0]    sym_out;

    assign head_cw       = CW'(head_reg);
    assign head_inc_cw   = CW'(head_reg) + CW'(1);
    assign extent_cw     = CW'(extent_reg);
    assign addr_cw       = CW'(addr_reg);
    assign wa_cw         = CW'(wa_reg);
    assign start_head_cw = CW'(start_head_reg);
    assign idx_ok        = CW'(rule_index_reg) < CW'(RULE_DEPTH);
    assign addr_ok       = addr_cw < CW'(TAPE_DEPTH);
    assign is_read       = (act_reg == ACT_READ_TAPE);

    // The read port always follows the head, except for a read-tape item.
    assign tape_raddr  = is_read ? addr_cw[AW-1:0] : head_reg;
    assign out_addr_cw = is_read ? addr_cw : head_cw;

    // Anything at or past the extent reads as blank; the extent never exceeds the depth.
    assign head_sym = (head_cw >= extent_cw) ? TME_BLANK : tape_rdata_reg;
    assign sym_out  = (out_addr_cw >= extent_cw) ? TME_BLANK : tape_rdata_reg;

    always_ff @(posedge aclk) begin
        if (tape_we) begin
            tape_mem[tape_waddr] <= tape_wdata;
        end
        tape_rdata_reg <= tape_mem[tape_raddr];
    end

    tme_rule_scan #(
        .RULE_DEPTH (RULE_DEPTH)
    ) u_scan (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (rule_wr_en),
        .wr_idx  (RIW'(rule_index_reg)),
        .wr_data (in_rule_reg),
        .req     (scan_req),
        .res     (scan_res)
    );

    assign s_ready  = (state_reg == ST_IDLE);
    assign out_load = (state_reg == ST_RESP) && (!m_valid_reg || m_ready);

    // Sequencer
    always_comb begin
        state_next     = state_reg;
        mstate_next    = mstate_reg;
        head_next      = head_reg;
        status_next    = status_reg;
        extent_next    = extent_reg;
        wa_next        = wa_reg;
        wd_next        = wd_reg;
        tape_we        = 1'b0;
        tape_waddr     = wa_reg;
        tape_wdata     = wd_reg;
        rule_wr_en     = 1'b0;
        scan_req.start = 1'b0;
        scan_req.state = mstate_reg;
        scan_req.sym   = head_sym;
        scan_req.count = rule_count_reg;

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_EXEC;
                end
            end

            ST_EXEC: begin
                state_next = ST_FINAL;
                case (act_reg)
                    ACT_LOAD_RULE: begin
                        rule_wr_en = idx_ok;
                    end
                    ACT_WRITE_TAPE: begin
                        // drop writes beyond the tape
                        if (addr_ok) begin
                            wa_next    = addr_cw[AW-1:0];
                            wd_next    = tsym_reg;
                            state_next = ST_WR;
                        end
                    end
                    ACT_RESTART: begin
                        mstate_next = start_state_reg;
                        head_next   = (start_head_cw >= CW'(TAPE_DEPTH)) ? AW'(TAPE_DEPTH - 1)
                                                                          : start_head_cw[AW-1:0];
                        status_next = RUN_RUNNING;
                    end
                    ACT_STEP: begin
                        // the head read issued this cycle lands in ST_SYM
                        if (status_reg == RUN_RUNNING) begin
                            state_next = ST_SYM;
                        end
                    end
                    default: begin
                        state_next = ST_FINAL;
                    end
                endcase
            end

            ST_SYM: begin
                scan_req.start = 1'b1;
                state_next     = ST_SCAN;
            end

            ST_SCAN: begin
                if (scan_res.done) begin
                    state_next = ST_FINAL;
                    if (!scan_res.hit) begin
                        status_next = RUN_NOMATCH;
                    end else begin
                        case (scan_res.rule.op)
                            OP_WRITE: begin
                                mstate_next = scan_res.rule.nx;
                                wa_next     = head_reg;
                                wd_next     = scan_res.rule.wr;
                                state_next  = ST_WR;
                            end
                            OP_RIGHT: begin
                                if (head_inc_cw >= CW'(TAPE_DEPTH)) begin
                                    // hold head and state at the last cell
                                    status_next = RUN_OVERFLOW;
                                end else begin
                                    mstate_next = scan_res.rule.nx;
                                    head_next   = head_inc_cw[AW-1:0];
                                    if (head_inc_cw >= extent_cw) begin
                                        // append a blank cell under the new head
                                        wa_next    = head_inc_cw[AW-1:0];
                                        wd_next    = TME_BLANK;
                                        state_next = ST_WR;
                                    end
                                end
                            end
                            OP_LEFT: begin
                                mstate_next = scan_res.rule.nx;
                                if (head_reg != '0) begin
                                    head_next = head_reg - AW'(1);
                                end
                            end
                            OP_HALT: begin
                                mstate_next = scan_res.rule.nx;
                                status_next = RUN_HALTED;
                            end
                            default: begin
                                state_next = ST_FINAL;
                            end
                        endcase
                    end
                end
            end

            ST_WR: begin
                tape_we = 1'b1;
                if (extent_cw < wa_cw) begin
                    // fill the skipped cell with blank and advance the extent
                    tape_waddr  = extent_cw[AW-1:0];
                    tape_wdata  = TME_BLANK;
                    extent_next = extent_reg + EW'(1);
                end else begin
                    tape_waddr = wa_reg;
                    tape_wdata = wd_reg;
                    if (extent_cw <= wa_cw) begin
                        extent_next = EW'(wa_cw + CW'(1));
                    end
                    state_next = ST_FINAL;
                end
            end

            ST_FINAL: begin
                state_next = ST_RESP;
            end

            ST_RESP: begin
                // hold until the output register is free
                if (!m_valid_reg || m_ready) begin
                    state_next = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (out_load) begin
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            mstate_reg      <= '0;
            head_reg        <= '0;
            status_reg      <= RUN_RUNNING;
            extent_reg      <= '0;
            start_state_reg <= '0;
            start_head_reg  <= '0;
            rule_count_reg  <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg   <= state_next;
            mstate_reg  <= mstate_next;
            head_reg    <= head_next;
            status_reg  <= status_next;
            extent_reg  <= extent_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_START_STATE: start_state_reg <= cfg_wdata[7:0];
                    CFG_START_HEAD:  start_head_reg  <= cfg_wdata;
                    CFG_RULE_COUNT:  rule_count_reg  <= cfg_wdata[6:0];
                    default: begin
                        start_state_reg <= start_state_reg;
                    end
                endcase
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        wa_reg <= wa_next;
        wd_reg <= wd_next;
        if (s_valid && s_ready) begin
            act_reg         <= s_action;
            rule_index_reg  <= s_rule_index;
            in_rule_reg.st  <= s_rule_state;
            in_rule_reg.sym <= s_rule_symbol;
            in_rule_reg.op  <= s_rule_op;
            in_rule_reg.wr  <= s_rule_write;
            in_rule_reg.nx  <= s_rule_next;
            addr_reg        <= s_tape_addr;
            tsym_reg        <= s_tape_symbol;
        end
        if (out_load) begin
            m_machine_state_reg <= mstate_reg;
            m_head_pos_reg      <= head_cw[9:0];
            m_symbol_out_reg    <= sym_out;
            m_run_state_reg     <= status_reg;
            m_extent_reg        <= extent_cw[10:0];
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_machine_state = m_machine_state_reg;
    assign m_head_pos      = m_head_pos_reg;
    assign m_symbol_out    = m_symbol_out_reg;
    assign m_run_state     = m_run_state_reg;
    assign m_extent        = m_extent_reg;

    // A waiting result must survive until the sink takes it.
    `TME_ASSERT_NEXT(a_hold_result, (state_reg == ST_RESP) && m_valid_reg && !m_ready, (state_reg == ST_RESP) && m_valid_reg)
    // An accepted beat always goes straight to dispatch.
    `TME_ASSERT_NEXT(a_accept_dispatch, s_valid && s_ready, state_reg == ST_EXEC)
    // The scanner reports only while the sequencer waits for it.
    `TME_ASSERT_IMPL(a_scan_done_in_scan, scan_res.done, state_reg == ST_SCAN)
    // A scan is started only for a running machine.
    `TME_ASSERT_IMPL(a_scan_when_running, scan_req.start, status_reg == RUN_RUNNING)
    // The extent never runs past the tape.
    `TME_ASSERT_IMPL(a_extent_bound, 1'b1, extent_cw <= CW'(TAPE_DEPTH))

endmodule

// File: rtl/tme_rule_scan.sv
module tme_rule_scan import tme_pkg::*; #(
    parameter int RULE_DEPTH = TME_RULE_DEPTH,
    localparam int RIW = (RULE_DEPTH > 1) ? $clog2(RULE_DEPTH) : 1,
    localparam int RCW = (RIW + 1 > 8) ? RIW + 1 : 8
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          wr_en,
    input  logic [RIW-1:0] wr_idx,
    input  tme_rule_t     wr_data,
    input  tme_scan_req_t req,
    output tme_scan_res_t res
);

    tme_rule_t rule_mem [RULE_DEPTH];
    tme_rule_t rd_data_reg;
    logic [RIW-1:0] rd_addr;

    logic           busy_reg, busy_next;
    logic           pend_reg, pend_next;
    logic [RCW-1:0] issued_reg, issued_next;
    logic [RCW-1:0] n_reg, n_next;
    logic [7:0]     st_reg, st_next;
    logic [7:0]     sym_reg, sym_next;
    logic [RCW-1:0] n_calc;
    logic           match;
    logic           done;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            rule_mem[wr_idx] <= wr_data;
        end
        rd_data_reg <= rule_mem[rd_addr];
    end

    // Clamp the scan length to the table depth.
    assign n_calc = (RCW'(req.count) > RCW'(RULE_DEPTH)) ? RCW'(RULE_DEPTH)
                                                          : RCW'(req.count);

    assign match = pend_reg && (rd_data_reg.st == st_reg) && (rd_data_reg.sym == sym_reg);
    assign done  = busy_reg && (match || (issued_reg >= n_reg));

    always_comb begin
        busy_next   = busy_reg;
        pend_next   = 1'b0;
        issued_next = issued_reg;
        n_next      = n_reg;
        st_next     = st_reg;
        sym_next    = sym_reg;
        rd_addr     = issued_reg[RIW-1:0];
        if (req.start) begin
            busy_next = 1'b1;
            n_next    = n_calc;
            st_next   = req.state;
            sym_next  = req.sym;
            rd_addr   = '0;
            if (n_calc != '0) begin
                pend_next   = 1'b1;
                issued_next = RCW'(1);
            end else begin
                issued_next = '0;
            end
        end else if (busy_reg) begin
            if (done) begin
                busy_next = 1'b0;
            end else begin
                // advance to the next slot, one compare per cycle
                pend_next   = 1'b1;
                issued_next = issued_reg + RCW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg   <= 1'b0;
            pend_reg   <= 1'b0;
            issued_reg <= '0;
            n_reg      <= '0;
        end else begin
            busy_reg   <= busy_next;
            pend_reg   <= pend_next;
            issued_reg <= issued_next;
            n_reg      <= n_next;
        end
    end

    always_ff @(posedge aclk) begin
        st_reg  <= st_next;
        sym_reg <= sym_next;
    end

    assign res.done = done;
    assign res.hit  = match;
    assign res.rule = rd_data_reg;

endmodule

// File: verif/tb_turing_machine_step_engine.sv
module tb_turing_machine_step_engine;
    import tme_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Actions the block must only report on.
    localparam logic [2:0] ACT_UNUSED_LO = 3'd5;
    localparam logic [2:0] ACT_UNUSED_HI = 3'd7;

    localparam int PHASE_COUNT = 6;
    localparam int PHASE_ITEMS = 108;

    // One input beat, field for field as the ports carry it.
    typedef struct packed {
        logic [2:0] action;
        logic [5:0] rule_index;
        logic [7:0] rule_state;
        logic [7:0] rule_symbol;
        logic [1:0] rule_op;
        logic [7:0] rule_write;
        logic [7:0] rule_next;
        logic [9:0] tape_addr;
        logic [7:0] tape_symbol;
    } tm_item_t;

    // One result beat.
    typedef struct packed {
        logic [7:0]  machine_state;
        logic [9:0]  head_pos;
        logic [7:0]  symbol_out;
        logic [1:0]  run_state;
        logic [10:0] extent;
    } tm_report_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;

    logic                  cfg_wr_en = 1'b0;
    logic [TME_CFG_IW-1:0] cfg_index = '0;
    logic [9:0]            cfg_wdata = '0;

    logic     s_valid = 1'b0;
    logic     s_ready;
    tm_item_t drv_item = '0;

    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [7:0]  m_machine_state;
    logic [9:0]  m_head_pos;
    logic [7:0]  m_symbol_out;
    logic [1:0]  m_run_state;
    logic [10:0] m_extent;

    turing_machine_step_engine dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_action        (drv_item.action),
        .s_rule_index    (drv_item.rule_index),
        .s_rule_state    (drv_item.rule_state),
        .s_rule_symbol   (drv_item.rule_symbol),
        .s_rule_op       (drv_item.rule_op),
        .s_rule_write    (drv_item.rule_write),
        .s_rule_next     (drv_item.rule_next),
        .s_tape_addr     (drv_item.tape_addr),
        .s_tape_symbol   (drv_item.tape_symbol),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_machine_state (m_machine_state),
        .m_head_pos      (m_head_pos),
        .m_symbol_out    (m_symbol_out),
        .m_run_state     (m_run_state),
        .m_extent        (m_extent)
    );

    // ------------------------------------------------------------------
    // Machine shadow: rule table, tape, head, state, status and the
    // register copies. Advanced once per accepted input beat.
    // ------------------------------------------------------------------
    tme_rule_t   rule_mem [TME_RULE_DEPTH];
    logic [7:0]  tape_mem [TME_TAPE_DEPTH];
    int unsigned tape_len = 0;
    logic [7:0]  mach_state = '0;
    int unsigned head_cell = 0;
    logic [1:0]  run_status = RUN_RUNNING;

    logic [7:0] cfg_start_state = '0;
    logic [9:0] cfg_start_head = '0;
    logic [6:0] cfg_rule_count = '0;

    // Stimulus and scoreboard storage.
    tm_item_t   pending_items [$];
    tm_report_t predicted_reports [$];

    int sender_idle_pct = 0;
    int recv_stall_pct = 0;

    int mismatches = 0;
    int beats_in = 0;
    int beats_checked = 0;
    int cfg_settings = 0;
    int steps_fired = 0;
    int steps_halted = 0;
    int steps_overflowed = 0;
    int steps_unmatched = 0;

    // Append one item to the tail of the stimulus queue.
    function automatic void enqueue_item(tm_item_t it);
        pending_items = {pending_items, it};
    endfunction

    // Cells at or past the extent read as blank.
    function automatic logic [7:0] tape_peek(int unsigned addr);
        if (addr >= tape_len || addr >= TME_TAPE_DEPTH)
            return TME_BLANK;
        return tape_mem[addr];
    endfunction

    // Writing past the extent pads the gap with blanks and grows the extent.
    function automatic void tape_poke(int unsigned addr, logic [7:0] value);
        if (addr >= TME_TAPE_DEPTH)
            return;
        while (tape_len < addr) begin
            tape_mem[tape_len] = TME_BLANK;
            tape_len++;
        end
        tape_mem[addr] = value;
        if (tape_len < addr + 1)
            tape_len = addr + 1;
    endfunction

    // One machine step: first matching rule among the scanned ones wins.
    function automatic void machine_step();
        int unsigned scan_len;
        logic [7:0]  under_head;
        scan_len = (cfg_rule_count < TME_RULE_DEPTH) ? cfg_rule_count : TME_RULE_DEPTH;
        under_head = tape_peek(head_cell);
        if (run_status != RUN_RUNNING)
            return;
        for (int i = 0; i < scan_len; i++) begin
            if (rule_mem[i].st == mach_state && rule_mem[i].sym == under_head) begin
                steps_fired++;
                case (rule_mem[i].op)
                    OP_WRITE: begin
                        tape_poke(head_cell, rule_mem[i].wr);
                    end
                    OP_RIGHT: begin
                        // Falling off the right end keeps head and state.
                        if (head_cell + 1 >= TME_TAPE_DEPTH) begin
                            run_status = RUN_OVERFLOW;
                            steps_overflowed++;
                            return;
                        end
                        head_cell++;
                        if (head_cell >= tape_len)
                            tape_poke(head_cell, TME_BLANK);
                    end
                    OP_LEFT: begin
                        // Cell zero is a wall; the next state is still taken.
                        if (head_cell > 0)
                            head_cell--;
                    end
                    default: begin
                        run_status = RUN_HALTED;
                        steps_halted++;
                    end
                endcase
                mach_state = rule_mem[i].nx;
                return;
            end
        end
        run_status = RUN_NOMATCH;
        steps_unmatched++;
    endfunction

    // Apply one accepted beat to the shadow and return the report it must produce.
    function automatic tm_report_t predict_item(tm_item_t it);
        tm_report_t rep;
        logic [7:0] sym;
        case (it.action)
            ACT_LOAD_RULE: begin
                rule_mem[it.rule_index] = '{st: it.rule_state, sym: it.rule_symbol,
                                            op: it.rule_op, wr: it.rule_write,
                                            nx: it.rule_next};
            end
            ACT_WRITE_TAPE: begin
                tape_poke(it.tape_addr, it.tape_symbol);
            end
            ACT_RESTART: begin
                mach_state = cfg_start_state;
                head_cell = (cfg_start_head < TME_TAPE_DEPTH) ? cfg_start_head
                                                             : TME_TAPE_DEPTH - 1;
                run_status = RUN_RUNNING;
            end
            ACT_STEP: begin
                machine_step();
            end
            default: ;
        endcase
        sym = (it.action == ACT_READ_TAPE) ? tape_peek(it.tape_addr) : tape_peek(head_cell);
        rep.machine_state = mach_state;
        rep.head_pos = 10'(head_cell);
        rep.symbol_out = sym;
        rep.run_state = run_status;
        rep.extent = 11'(tape_len);
        return rep;
    endfunction

    // ------------------------------------------------------------------
    // Mismatch reporting
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        mismatches++;
    endtask

    task automatic check_field(input string name, input logic [10:0] got,
                               input logic [10:0] want);
        if (got !== want)
            report_mismatch($sformatf("beat %0d %s: got %0d, expected %0d",
                                      beats_checked, name, got, want));
    endtask

    // ------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------
    initial begin
        forever #2 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // Input driver: hold a beat until it is taken, then pop the next one
    // unless the idle roll says to leave a gap. Predict on acceptance.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : input_driver
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                predicted_reports = {predicted_reports, predict_item(drv_item)};
                beats_in++;
            end
            // A stalled beat keeps valid and payload as they are.
            if (!(s_valid && !s_ready)) begin
                if (pending_items.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
                    drv_item <= pending_items.pop_front();
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Result monitor: compare each taken beat with the oldest prediction,
    // then roll the stall for the next cycle.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : result_monitor
        tm_report_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (predicted_reports.size() == 0) begin
                    report_mismatch("result beat with no prediction pending");
                end else begin
                    want = predicted_reports.pop_front();
                    check_field("machine_state", m_machine_state, want.machine_state);
                    check_field("head_pos", m_head_pos, want.head_pos);
                    check_field("symbol_out", m_symbol_out, want.symbol_out);
                    check_field("run_state", m_run_state, want.run_state);
                    check_field("extent", m_extent, want.extent);
                    beats_checked++;
                end
            end
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Every field random; callers override what matters, the rest is junk
    // the block has to ignore.
    function automatic tm_item_t random_item();
        logic [63:0] raw;
        raw = {$urandom(), $urandom()};
        return raw[$bits(tm_item_t)-1:0];
    endfunction

    function automatic tm_item_t bare_item(logic [2:0] act);
        tm_item_t it;
        it = random_item();
        it.action = act;
        return it;
    endfunction

    function automatic tm_item_t tape_item(logic [2:0] act, logic [9:0] addr,
                                           logic [7:0] sym);
        tm_item_t it;
        it = bare_item(act);
        it.tape_addr = addr;
        it.tape_symbol = sym;
        return it;
    endfunction

    function automatic tm_item_t rule_item(logic [5:0] slot, logic [7:0] st,
                                           logic [7:0] sym, logic [1:0] op,
                                           logic [7:0] wr, logic [7:0] nx);
        tm_item_t it;
        it = bare_item(ACT_LOAD_RULE);
        it.rule_index = slot;
        it.rule_state = st;
        it.rule_symbol = sym;
        it.rule_op = op;
        it.rule_write = wr;
        it.rule_next = nx;
        return it;
    endfunction

    // Small working alphabet so that rules actually meet the tape.
    function automatic logic [7:0] pick_symbol();
        int r;
        r = $urandom_range(99);
        if (r < 40)
            return TME_BLANK;
        if (r < 65)
            return 8'h30;
        if (r < 88)
            return 8'h31;
        return 8'($urandom());
    endfunction

    // Mostly a four-state program; the rest are noise rules with any fields.
    function automatic tm_item_t program_rule(logic [5:0] slot);
        tm_item_t it;
        int       r;
        it = bare_item(ACT_LOAD_RULE);
        it.rule_index = slot;
        if ($urandom_range(99) < 85) begin
            it.rule_state = 8'($urandom_range(3));
            it.rule_symbol = pick_symbol();
            it.rule_write = pick_symbol();
            it.rule_next = 8'($urandom_range(3));
            r = $urandom_range(99);
            if (r < 35)
                it.rule_op = OP_WRITE;
            else if (r < 65)
                it.rule_op = OP_RIGHT;
            else if (r < 92)
                it.rule_op = OP_LEFT;
            else
                it.rule_op = OP_HALT;
        end
        return it;
    endfunction

    function automatic tm_item_t mixed_item();
        int r;
        r = $urandom_range(99);
        if (r < 45)
            return bare_item(ACT_STEP);
        if (r < 55)
            return bare_item(ACT_RESTART);
        if (r < 67)
            return tape_item(ACT_WRITE_TAPE,
                             ($urandom_range(99) < 95) ? 10'($urandom_range(47))
                                                       : 10'($urandom()),
                             pick_symbol());
        if (r < 78)
            return tape_item(ACT_READ_TAPE,
                             ($urandom_range(99) < 90) ? 10'($urandom_range(63))
                                                       : 10'($urandom()),
                             8'($urandom()));
        if (r < 96)
            return program_rule(6'($urandom()));
        return bare_item(3'($urandom_range(ACT_UNUSED_LO, ACT_UNUSED_HI)));
    endfunction

    // Sample at the falling edge so the driver and monitor have settled.
    task automatic wait_idle();
        while (pending_items.size() != 0 || s_valid || predicted_reports.size() != 0)
            @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [TME_CFG_IW-1:0] idx, input logic [9:0] value);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        case (idx)
            CFG_START_STATE: cfg_start_state = value[7:0];
            CFG_START_HEAD:  cfg_start_head = value;
            CFG_RULE_COUNT:  cfg_rule_count = value[6:0];
            default: ;
        endcase
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // Only ever called with the block drained.
    task automatic set_config(input logic [7:0] st, input logic [9:0] hd,
                              input logic [6:0] cnt);
        write_reg(CFG_START_STATE, {2'b00, st});
        write_reg(CFG_START_HEAD, hd);
        write_reg(CFG_RULE_COUNT, {3'b000, cnt});
        cfg_settings++;
        @(negedge aclk);
    endtask

    // ------------------------------------------------------------------
    // Run limit
    // ------------------------------------------------------------------
    initial begin
        #2ms;
        $display("timeout: %0d beats in flight, %0d not yet sent",
                 predicted_reports.size(), pending_items.size());
        $display("FAIL");
        $finish;
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        tm_item_t it;

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed, part one: no rules scanned, tape basics, unused actions.
        set_config(8'd255, 10'd5, 7'd0);
        enqueue_item(bare_item(ACT_STEP));                       // empty scan
        enqueue_item(tape_item(ACT_READ_TAPE, 10'd1023, 8'h00)); // past extent
        enqueue_item(tape_item(ACT_WRITE_TAPE, 10'd5, 8'hFF));   // pad gap
        enqueue_item(tape_item(ACT_READ_TAPE, 10'd5, 8'h00));
        enqueue_item(tape_item(ACT_READ_TAPE, 10'd0, 8'h00));    // padded blank
        it = '1;
        it.action = ACT_UNUSED_HI;
        enqueue_item(it);
        it = '0;
        it.action = ACT_UNUSED_LO;
        enqueue_item(it);
        enqueue_item(bare_item(ACT_RESTART));
        // Little program exercising every operation.
        enqueue_item(rule_item(6'd0, 8'd255, 8'hFF, OP_RIGHT, 8'h00, 8'd1));
        enqueue_item(rule_item(6'd1, 8'd1, TME_BLANK, OP_WRITE, 8'h41, 8'd2));
        enqueue_item(rule_item(6'd2, 8'd2, 8'h41, OP_LEFT, 8'h00, 8'd3));
        enqueue_item(rule_item(6'd3, 8'd3, 8'hFF, OP_HALT, 8'h00, 8'd4));
        enqueue_item(rule_item(6'd4, 8'd10, TME_BLANK, OP_LEFT, 8'h00, 8'd7));
        enqueue_item(rule_item(6'd5, 8'd7, TME_BLANK, OP_RIGHT, 8'h00, 8'd8));
        enqueue_item(rule_item(6'd6, 8'd8, TME_BLANK, OP_WRITE, 8'h00, 8'd0));
        wait_idle();

        // Directed, part two: move right onto the extent, write, left, halt,
        // then a step while halted.
        set_config(8'd255, 10'd5, 7'd7);
        repeat (5) enqueue_item(bare_item(ACT_STEP));
        wait_idle();

        // Directed, part three: left at cell zero, a move right and a write, then no rule matches.
        set_config(8'd10, 10'd0, 7'd7);
        enqueue_item(bare_item(ACT_RESTART));
        repeat (4) enqueue_item(bare_item(ACT_STEP));
        wait_idle();

        // Directed, part four: move right off the last cell, then a stuck step.
        set_config(8'd7, 10'd1023, 7'd7);
        enqueue_item(bare_item(ACT_RESTART));
        repeat (2) enqueue_item(bare_item(ACT_STEP));
        wait_idle();

        // Random phases. Phase zero loads the whole table first, so every
        // later scan only meets loaded slots. The last phase parks the head on
        // the final cell, which can fill the whole tape.
        for (int p = 0; p < PHASE_COUNT; p++) begin
            case (p)
                0: set_config(8'd0, 10'd0, 7'd64);
                1: set_config(8'd1, 10'd30, 7'd16);
                2: set_config(8'd2, 10'd0, 7'd127);
                3: set_config(8'd255, 10'd512, 7'd1);
                4: set_config(8'd3, 10'd700, 7'd100);
                default: set_config(8'd0, 10'd1023, 7'd64);
            endcase
            case (p % 4)
                0: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin sender_idle_pct = 63; recv_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  recv_stall_pct = 63; end
                default: begin sender_idle_pct = 24; recv_stall_pct = 24; end
            endcase
            if (p == 0)
                for (int s = 0; s < TME_RULE_DEPTH; s++)
                    enqueue_item(program_rule(6'(s)));
            enqueue_item(bare_item(ACT_RESTART));
            for (int n = 0; n < PHASE_ITEMS; n++)
                enqueue_item(mixed_item());
            wait_idle();
        end

        // Let any stray result beat show up before closing.
        sender_idle_pct = 0;
        recv_stall_pct = 0;
        repeat (80) @(posedge aclk);

        $display("covered %0d beats (%0d checked) over %0d register settings",
                 beats_in, beats_checked, cfg_settings);
        $display("steps: %0d fired, %0d halted, %0d overflowed, %0d found no rule",
                 steps_fired, steps_halted, steps_overflowed, steps_unmatched);
        if (mismatches == 0 && predicted_reports.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
